### rtl/pfma_pkg.sv
// ----------------------------------------------------------------------------
// Per-pixel frame moving average: shared definitions
// Sizes, register indexes, reset values and pipeline types of the block.
// ----------------------------------------------------------------------------
package pfma_pkg;

  localparam int MAX_PIXELS  = 1024;
  localparam int MAX_WINDOW  = 128;

  localparam int DATA_W      = 32;
  localparam int PIX_W       = $clog2(MAX_PIXELS);
  localparam int FRAME_W     = PIX_W + 1;
  localparam int WIN_W       = 8;
  localparam int WIN_IDX_W   = $clog2(MAX_WINDOW);

  localparam int HIST_ROW    = MAX_WINDOW + 1;
  localparam int HIST_DEPTH  = MAX_PIXELS * HIST_ROW;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);

  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int OCC_W       = FIFO_AW + 1;
  localparam int FWD_DEPTH   = 4;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic REG_WINDOW_LENGTH    = 1'b0;
  localparam logic REG_PIXELS_PER_FRAME = 1'b1;

  localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST    = 8'd100;
  localparam logic [FRAME_W-1:0] PIXELS_PER_FRAME_RST = 11'd1024;

  typedef struct packed {
    logic               last;
    logic [PIX_W-1:0]   pix;
    logic               neg;
    logic               inv;
    logic [HIST_AW-1:0] hwa;
    logic [HIST_AW-1:0] hra;
  } meta_t;

  typedef struct packed {
    logic              last;
    logic [PIX_W-1:0]  pix;
    logic [DATA_W-1:0] avg;
  } result_t;

endpackage

### rtl/pfma_divider.sv
// ----------------------------------------------------------------------------
// Window divider
// Divides a 32-bit magnitude by the window length through a reciprocal
// multiply and one correction step, pipelined in recip_r, prod_r and q0_r.
// ----------------------------------------------------------------------------
module pfma_divider (
  input  logic                          clk,
  input  logic [pfma_pkg::DATA_W-1:0]   dividend,
  input  logic [pfma_pkg::WIN_W-1:0]    divisor,
  output logic [pfma_pkg::DATA_W-1:0]   quotient
);
  import pfma_pkg::*;

  logic [DATA_W-1:0]       recip_tab [MAX_WINDOW];
  logic [DATA_W-1:0]       recip_r;
  logic [2*DATA_W-1:0]     prod_r;
  logic [DATA_W-1:0]       dvd2_r;
  logic [DATA_W-1:0]       dvd3_r;
  logic [DATA_W-1:0]       q0_r;
  logic [DATA_W-1:0]       qw_r;
  logic [DATA_W+WIN_W-1:0] qw_full;
  logic [DATA_W-1:0]       rem;

  for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_recip
    localparam longint unsigned RecipVal = ((64'd1 << DATA_W) - 64'd1) / (gi + 1);
    assign recip_tab[gi] = DATA_W'(RecipVal);
  end

  assign qw_full  = (DATA_W+WIN_W)'(prod_r[2*DATA_W-1:DATA_W]) * (DATA_W+WIN_W)'(divisor);
  assign rem      = dvd3_r - qw_r;
  assign quotient = (rem >= DATA_W'(divisor)) ? q0_r + DATA_W'(1) : q0_r;

  always_ff @(posedge clk) begin
    recip_r <= recip_tab[WIN_IDX_W'(divisor - WIN_W'(1))];
    prod_r  <= (2*DATA_W)'(dividend) * (2*DATA_W)'(recip_r);
    dvd2_r  <= dividend;
    q0_r    <= prod_r[2*DATA_W-1:DATA_W];
    qw_r    <= qw_full[DATA_W-1:0];
    dvd3_r  <= dvd2_r;
  end

endmodule

### rtl/per_pixel_frame_moving_average.sv
// ----------------------------------------------------------------------------
// Per-pixel frame moving average
// Keeps a boxcar average over the last window_length frames for every pixel
// of a raster stream, with history and sums held in on-chip memories.
// ----------------------------------------------------------------------------
// The block takes one pixel transfer per clock while in_tready is high and
// returns one result per pixel, through stage registers v1_r to v4_r and the result queue.
// Each sample's magnitude is divided by the window length in a reciprocal
// pipeline while the pixel's history memory and sum memory are read, then
// updated and written back; results from nearby pixels of very short frames
// are forwarded around the memories. Results wait in an eight-entry queue,
// so input is taken while the output is stalled until that queue is
// committed. After reset a clearing pass zeroes all 132096 history entries,
// one entry per cycle, and the sum memory with them; in_tready stays low
// during that pass, while register writes are taken as usual.
module per_pixel_frame_moving_average (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pfma_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] sample
  input  logic [0:0]                          in_tuser,   // [0] sample_invalid
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pfma_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [31:0] average, [41:32] pixel_index
  output logic                                out_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pfma_pkg::CFG_AW-1:0]         paddr,
  input  logic [pfma_pkg::CFG_DW-1:0]         pwdata,
  output logic [pfma_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);
  import pfma_pkg::*;

  logic [WIN_W-1:0]   window_length_r;
  logic [FRAME_W-1:0] pixels_per_frame_r;
  logic               cfg_wr;
  logic [WIN_W-1:0]   w_eff;
  logic [FRAME_W-1:0] p_eff;

  logic [PIX_W-1:0]   pixel_cnt_r;
  logic [WIN_W-1:0]   write_slot_r;
  logic [WIN_W-1:0]   slot;
  logic [WIN_W-1:0]   next_slot;
  logic               frame_last;
  logic [HIST_AW-1:0] row_base;
  logic [HIST_AW-1:0] hwa;
  logic [HIST_AW-1:0] hra;
  logic signed [DATA_W-1:0] sample;
  logic [DATA_W-1:0]  sample_mag;
  logic               in_acc;

  logic               v1_r, v2_r, v3_r, v4_r;
  meta_t              meta1_r, meta2_r, meta3_r, meta4_r;
  logic [DATA_W-1:0]  mag1_r;
  logic [DATA_W-1:0]  hist2_r, hist3_r, hist4_r;
  logic [DATA_W-1:0]  sum2_r, sum3_r, sum4_r;
  logic [DATA_W-1:0]  q_mag;
  logic [DATA_W-1:0]  scaled_nxt;
  logic [DATA_W-1:0]  scaled4_r;

  logic [DATA_W-1:0]  hist_mem [HIST_DEPTH];
  logic [DATA_W-1:0]  sum_mem [MAX_PIXELS];
  logic [DATA_W-1:0]  hist_rd_r;
  logic [DATA_W-1:0]  sum_rd_r;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_wa;
  logic [DATA_W-1:0]  hist_wd;
  logic               sum_we;
  logic [PIX_W-1:0]   sum_wa;
  logic [DATA_W-1:0]  sum_wd;

  logic               clr_active_r;
  logic [HIST_AW-1:0] clr_addr_r;

  logic               wb_v_r    [FWD_DEPTH];
  logic [PIX_W-1:0]   wb_pix_r  [FWD_DEPTH];
  logic [DATA_W-1:0]  wb_sum_r  [FWD_DEPTH];
  logic [HIST_AW-1:0] wb_hwa_r  [FWD_DEPTH];
  logic [DATA_W-1:0]  wb_hval_r [FWD_DEPTH];
  logic [DATA_W-1:0]  sum_base;
  logic [DATA_W-1:0]  hist_base;
  logic [DATA_W-1:0]  sum_new;

  result_t            fifo_mem [FIFO_DEPTH];
  result_t            head;
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [OCC_W-1:0]   fifo_cnt_r;
  logic [OCC_W-1:0]   occ_r;
  logic               out_acc;

  // Configuration registers.
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r    <= WINDOW_LENGTH_RST;
      pixels_per_frame_r <= PIXELS_PER_FRAME_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH:    window_length_r    <= pwdata[WIN_W-1:0];
        REG_PIXELS_PER_FRAME: pixels_per_frame_r <= pwdata[FRAME_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LENGTH:    prdata = CFG_DW'(window_length_r);
      REG_PIXELS_PER_FRAME: prdata = CFG_DW'(pixels_per_frame_r);
    endcase
  end

  assign w_eff = (window_length_r == '0) ? WIN_W'(1) :
                 (window_length_r > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) :
                 window_length_r;
  assign p_eff = (pixels_per_frame_r == '0) ? FRAME_W'(1) :
                 (pixels_per_frame_r > FRAME_W'(MAX_PIXELS)) ? FRAME_W'(MAX_PIXELS) :
                 pixels_per_frame_r;

  // Front stage: pixel position, ring slots and memory addresses.
  assign in_acc     = in_tvalid & in_tready;
  assign in_tready  = !clr_active_r && (occ_r < OCC_W'(FIFO_DEPTH));
  assign slot       = (write_slot_r > w_eff) ? '0 : write_slot_r;
  assign next_slot  = (slot == w_eff) ? '0 : slot + WIN_W'(1);
  assign frame_last = (FRAME_W'(pixel_cnt_r) + FRAME_W'(1)) >= p_eff;
  assign row_base   = HIST_AW'(pixel_cnt_r) * HIST_AW'(HIST_ROW);
  assign hwa        = row_base + HIST_AW'(slot);
  assign hra        = row_base + HIST_AW'(next_slot);
  assign sample     = in_tdata;
  assign sample_mag = sample[DATA_W-1] ? (~in_tdata + DATA_W'(1)) : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_cnt_r  <= '0;
      write_slot_r <= '0;
    end else if (in_acc) begin
      if (frame_last) begin
        pixel_cnt_r  <= '0;
        write_slot_r <= next_slot;
      end else begin
        pixel_cnt_r  <= pixel_cnt_r + PIX_W'(1);
      end
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    meta1_r.last <= frame_last;
    meta1_r.pix  <= pixel_cnt_r;
    meta1_r.neg  <= sample[DATA_W-1];
    meta1_r.inv  <= in_tuser[0];
    meta1_r.hwa  <= hwa;
    meta1_r.hra  <= hra;
    mag1_r       <= sample_mag;
    meta2_r      <= meta1_r;
    hist2_r      <= hist_rd_r;
    sum2_r       <= sum_rd_r;
    meta3_r      <= meta2_r;
    hist3_r      <= hist2_r;
    sum3_r       <= sum2_r;
    meta4_r      <= meta3_r;
    hist4_r      <= hist3_r;
    sum4_r       <= sum3_r;
    scaled4_r    <= scaled_nxt;
  end

  pfma_divider u_div (
    .clk      (clk),
    .dividend (mag1_r),
    .divisor  (w_eff),
    .quotient (q_mag)
  );

  assign scaled_nxt = meta3_r.inv ? '0 : (meta3_r.neg ? (~q_mag + DATA_W'(1)) : q_mag);

  // The last four write-backs cover every older item whose write lands after this
  // item's memory reads were issued.
  always_comb begin
    sum_base  = sum4_r;
    hist_base = hist4_r;
    for (int k = FWD_DEPTH - 1; k >= 0; k--) begin
      if (wb_v_r[k] && (wb_pix_r[k] == meta4_r.pix)) begin
        sum_base = wb_sum_r[k];
      end
      if (wb_v_r[k] && (wb_hwa_r[k] == meta4_r.hra)) begin
        hist_base = wb_hval_r[k];
      end
    end
  end

  assign sum_new = sum_base + scaled4_r - hist_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FWD_DEPTH; k++) begin
        wb_v_r[k] <= 1'b0;
      end
    end else begin
      wb_v_r[0] <= v4_r;
      for (int k = 1; k < FWD_DEPTH; k++) begin
        wb_v_r[k] <= wb_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_pix_r[0]  <= meta4_r.pix;
    wb_sum_r[0]  <= sum_new;
    wb_hwa_r[0]  <= meta4_r.hwa;
    wb_hval_r[0] <= scaled4_r;
    for (int k = 1; k < FWD_DEPTH; k++) begin
      wb_pix_r[k]  <= wb_pix_r[k-1];
      wb_sum_r[k]  <= wb_sum_r[k-1];
      wb_hwa_r[k]  <= wb_hwa_r[k-1];
      wb_hval_r[k] <= wb_hval_r[k-1];
    end
  end

  // Clearing pass over both memories after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == HIST_AW'(HIST_DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + HIST_AW'(1);
    end
  end

  assign hist_we = clr_active_r || v4_r;
  assign hist_wa = clr_active_r ? clr_addr_r : meta4_r.hwa;
  assign hist_wd = clr_active_r ? '0 : scaled4_r;
  assign sum_we  = (clr_active_r && (clr_addr_r < HIST_AW'(MAX_PIXELS))) || v4_r;
  assign sum_wa  = clr_active_r ? clr_addr_r[PIX_W-1:0] : meta4_r.pix;
  assign sum_wd  = clr_active_r ? '0 : sum_new;

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_r <= hist_mem[hra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rd_r <= sum_mem[pixel_cnt_r];
  end

  // Result queue.
  assign out_acc    = out_tvalid & out_tready;
  assign out_tvalid = (fifo_cnt_r != '0);
  assign head       = fifo_mem[rd_ptr_r];
  assign out_tdata  = {(OUT_TDATA_W - DATA_W - PIX_W)'(0), head.pix, head.avg};
  assign out_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (v4_r) begin
      fifo_mem[wr_ptr_r] <= '{last: meta4_r.last, pix: meta4_r.pix, avg: sum_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      if (v4_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + OCC_W'(v4_r) - OCC_W'(out_acc);
      occ_r      <= occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(FIFO_DEPTH))
    else $error("occupancy exceeds queue depth");

  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == fifo_cnt_r + OCC_W'(v1_r) + OCC_W'(v2_r) + OCC_W'(v3_r) + OCC_W'(v4_r))
    else $error("occupancy does not match items in flight");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (fifo_cnt_r != OCC_W'(FIFO_DEPTH)))
    else $error("result written into a full queue");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> ($past(clr_addr_r) == HIST_AW'(HIST_DEPTH - 1)))
    else $error("clearing pass ended early");
`endif

endmodule

### test/per_pixel_frame_moving_average_checker.sv
// ----------------------------------------------------------------------------
// Per-pixel frame moving average: stream checker
// Watches the pixel, result and register ports, keeps its own copy of the
// per-pixel history and sums, predicts every result and compares it field by
// field with what the block returns. Register reads are compared as well.
// ----------------------------------------------------------------------------
module per_pixel_frame_moving_average_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [pfma_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] sample
  input  logic [0:0]                       in_tuser,   // [0] sample_invalid
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [pfma_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] average, [41:32] pixel_index
  input  logic                             out_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfma_pkg::CFG_AW-1:0]      paddr,
  input  logic [pfma_pkg::CFG_DW-1:0]      pwdata,
  input  logic [pfma_pkg::CFG_DW-1:0]      prdata,
  input  logic                             pready,
  output int                               errors,
  output int                               pending
);
  import pfma_pkg::*;

  bit [DATA_W-1:0]  history [HIST_DEPTH];
  bit [DATA_W-1:0]  pixel_sums [MAX_PIXELS];
  int unsigned      next_pixel;
  int unsigned      frame_slot;
  logic [WIN_W-1:0]   window_reg;
  logic [FRAME_W-1:0] frame_reg;
  result_t          expected_averages [$];
  int               failure_count = 0;
  int               outstanding = 0;

  assign errors  = failure_count;
  assign pending = outstanding;

  function automatic result_t predict_average(input logic [DATA_W-1:0] smp, input logic inv);
    int unsigned win;
    int unsigned frame_len;
    int unsigned slot;
    int unsigned next_slot;
    int unsigned pix;
    longint      quotient;
    logic [DATA_W-1:0] scaled;
    result_t     res;
    win       = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
    frame_len = (frame_reg == 0) ? 1 : (frame_reg > MAX_PIXELS) ? MAX_PIXELS : frame_reg;
    pix       = next_pixel % MAX_PIXELS;
    slot      = (frame_slot > win) ? 0 : frame_slot;
    next_slot = (slot == win) ? 0 : slot + 1;
    quotient  = longint'($signed(smp)) / longint'(win);
    scaled    = inv ? '0 : quotient[DATA_W-1:0];
    history[pix*HIST_ROW + slot] = scaled;
    pixel_sums[pix] = pixel_sums[pix] + scaled - history[pix*HIST_ROW + next_slot];
    res.avg  = pixel_sums[pix];
    res.pix  = pix[PIX_W-1:0];
    res.last = (next_pixel + 1 >= frame_len);
    if (res.last) begin
      next_pixel = 0;
      frame_slot = next_slot;
    end else begin
      next_pixel = next_pixel + 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    logic [CFG_AW-1:0] reg_idx;
    logic [CFG_DW-1:0] reg_value;
    if (!rst_n) begin
      foreach (history[i]) history[i] = '0;
      foreach (pixel_sums[i]) pixel_sums[i] = '0;
      next_pixel = 0;
      frame_slot = 0;
      window_reg = WINDOW_LENGTH_RST;
      frame_reg  = PIXELS_PER_FRAME_RST;
      expected_averages.delete();
    end else begin
      reg_idx = paddr >> 2;
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (reg_idx == REG_WINDOW_LENGTH) window_reg = pwdata[WIN_W-1:0];
          else if (reg_idx == REG_PIXELS_PER_FRAME) frame_reg = pwdata[FRAME_W-1:0];
        end else begin
          reg_value = (reg_idx == REG_WINDOW_LENGTH) ? CFG_DW'(window_reg) : CFG_DW'(frame_reg);
          if (prdata !== reg_value) begin
            $display("%0t: register %0d read: expected %h, actual %h",
                     $time, reg_idx, reg_value, prdata);
            failure_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_averages.push_back(predict_average(in_tdata[DATA_W-1:0], in_tuser[0]));
      if (out_tvalid && out_tready) begin
        got.avg  = out_tdata[DATA_W-1:0];
        got.pix  = out_tdata[DATA_W +: PIX_W];
        got.last = out_tlast;
        if (expected_averages.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual avg %h pix %0d last %b",
                   $time, got.avg, got.pix, got.last);
          failure_count++;
        end else begin
          want = expected_averages.pop_front();
          if (got.avg !== want.avg) begin
            $display("%0t: average: expected %h, actual %h", $time, want.avg, got.avg);
            failure_count++;
          end
          if (got.pix !== want.pix) begin
            $display("%0t: pixel_index: expected %0d, actual %0d", $time, want.pix, got.pix);
            failure_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_of_frame: expected %b, actual %b", $time, want.last, got.last);
            failure_count++;
          end
        end
      end
    end
    outstanding = expected_averages.size();
  end

endmodule

### test/per_pixel_frame_moving_average_tb.sv
// ----------------------------------------------------------------------------
// Per-pixel frame moving average: testbench top
// Drives pixel transfers and register writes into the block through several
// window and frame settings, stalls both stream sides in random bursts, and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module per_pixel_frame_moving_average_tb;
  import pfma_pkg::*;

  localparam int WATCHDOG_LIMIT = 800000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] sample
  logic [0:0]             in_tuser = '0;   // [0] sample_invalid
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [31:0] average, [41:32] pixel_index
  logic                   out_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_AW-1:0]      paddr = '0;
  logic [CFG_DW-1:0]      pwdata = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;
  int                     errors;
  int                     pending;
  bit                     no_stall = 1'b0;
  int                     quiet_cycles = 0;

  per_pixel_frame_moving_average dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  per_pixel_frame_moving_average_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors, .pending
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (no_stall) begin
        out_tready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        hold = $urandom_range(0, 20);
      end else begin
        out_tready <= 1'b0;
        hold = $urandom_range(0, 12);
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_pixel(input logic [DATA_W-1:0] smp, input logic inv);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= inv;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_access(input logic reg_sel, input logic wr, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_AW'({reg_sel, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_DW-1:0] win, input logic [CFG_DW-1:0] frame);
    drain;
    cfg_access(REG_WINDOW_LENGTH, 1'b1, win);
    cfg_access(REG_PIXELS_PER_FRAME, 1'b1, frame);
    cfg_access(REG_WINDOW_LENGTH, 1'b0, '0);
    cfg_access(REG_PIXELS_PER_FRAME, 1'b0, '0);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample;
    int kind;
    logic [DATA_W-1:0] mag;
    kind = $urandom_range(0, 9);
    mag  = $urandom_range(0, 32'h0010_0000);
    case (kind)
      0: pick_sample = 32'h7FFF_FFFF;
      1: pick_sample = 32'h8000_0000;
      2: pick_sample = mag;
      3: pick_sample = -mag;
      default: pick_sample = $urandom;
    endcase
  endfunction

  task automatic run_phase(input logic [CFG_DW-1:0] win, input logic [CFG_DW-1:0] frame,
                           input int count, input bit quiet);
    configure(win, frame);
    no_stall = quiet || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (!no_stall && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 13));
      if (!quiet && $urandom_range(0, 149) == 0) drain;
      send_pixel(pick_sample(), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(32'h7FFF_FFFF, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0001, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h1234_5678, 1'b1);
    send_pixel(32'h8000_0000, 1'b1);
    send_pixel(32'd99, 1'b0);
    send_pixel(-32'sd99, 1'b0);
    send_pixel(32'd100, 1'b0);
    send_pixel(-32'sd100, 1'b0);

    configure(32'd1, 32'd1);
    send_pixel(32'h7FFF_FFFF, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0005_0000, 1'b0);

    configure(32'd0, 32'd0);
    send_pixel(32'h0003_0000, 1'b0);
    send_pixel(32'hFFFD_0000, 1'b0);

    configure(32'd255, 32'd2047);
    send_pixel(32'h7FFF_FFFF, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);

    run_phase(32'd3, 32'd4, 150, 1'b0);
    run_phase(32'd128, 32'd2, 300, 1'b0);
    run_phase(32'd5, 32'd7, 150, 1'b0);
    run_phase(32'd0, 32'd0, 40, 1'b0);
    run_phase(32'h0000_0303, 32'd1024, 520, 1'b0);
    run_phase(32'd16, 32'd3, 150, 1'b0);
    run_phase(32'd129, 32'd1, 150, 1'b0);
    run_phase(32'd7, 32'd5, 150, 1'b0);
    run_phase(32'd1, 32'd1, 60, 1'b0);
    run_phase(32'd4, 32'd6, 200, 1'b1);

    drain;
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pfma_pkg.sv
rtl/pfma_divider.sv
rtl/per_pixel_frame_moving_average.sv
test/per_pixel_frame_moving_average_checker.sv
test/per_pixel_frame_moving_average_tb.sv
